// ===== hdl/epg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epg_pkg: shared types and constants of the ellipse pixel generator
// Request codes, datapath operation codes and the status bundle passed
// from the datapath to the controller.
// ---------------------------------------------------------------------------
package epg_pkg;

  localparam int CENTER_W = 15;
  localparam int RADIUS_W = 12;
  localparam int SQ_W     = 25;
  localparam int TERM_W   = 48;
  localparam int MUL_A_W  = 26;
  localparam int MUL_B_W  = 14;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int SUM_W    = 17;
  localparam int OUT_W    = 16;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_MUL_RX   = 4'd2;
  localparam op_t OP_MUL_RY   = 4'd3;
  localparam op_t OP_MUL_CX   = 4'd4;
  localparam op_t OP_MUL_SX   = 4'd5;
  localparam op_t OP_INIT     = 4'd6;
  localparam op_t OP_SW_CY    = 4'd7;
  localparam op_t OP_SW_SY    = 4'd8;
  localparam op_t OP_SW_INIT  = 4'd9;
  localparam op_t OP_STEP_A   = 4'd10;
  localparam op_t OP_STEP_B   = 4'd11;
  localparam op_t OP_EMIT     = 4'd12;
  localparam op_t OP_EMIT_INV = 4'd13;
  localparam op_t OP_FINISH   = 4'd14;

  typedef struct packed {
    logic done;
    logic pending;
    logic region;
    logic advance;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/ellipse_pixel_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ellipse_pixel_generator_unit: midpoint ellipse rasterizer, one pixel per request
// Request channel (in_valid/in_ready): cmd start loads centre and radii,
// cmd next asks for the following pixel. Result channel (out_valid/out_ready)
// returns exactly one result per request: a pixel, or pixel_valid low once
// the ellipse is finished or before any start.
// Requests are served one at a time. Work done from accept to result loaded:
//   start            four passes through the shared 26x14 multiplier
//   mirror pixel     pop of the pending mirrored point
//   new point        two-step midpoint step over the 48-bit terms
//   region switch    two multiplies
//   finished         answer with an invalid result
// A request may be accepted while the previous result still waits; the new
// result is held back until the output register is taken.
// Reset leaves the block finished: next requests return invalid results
// until a start is accepted.
// ---------------------------------------------------------------------------
module ellipse_pixel_generator_unit #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RADIUS = 4095
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                cmd,
  input  wire signed [epg_pkg::CENTER_W-1:0] center_x,
  input  wire signed [epg_pkg::CENTER_W-1:0] center_y,
  input  wire        [epg_pkg::RADIUS_W-1:0] radius_x,
  input  wire        [epg_pkg::RADIUS_W-1:0] radius_y,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [COORD_BITS-1:0]       pixel_x,
  output logic signed [COORD_BITS-1:0]       pixel_y,
  output logic                               pixel_valid
);

  epg_pkg::status_t status;
  epg_pkg::op_t     op;

  epg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  epg_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .status      (status),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another was in progress");

  // mirrored pixels never remain pending on a finished ellipse
  a_pending_not_done: assert property (@(posedge clk) disable iff (rst)
    status.pending |-> !status.done)
    else $error("mirror pixels pending after the ellipse finished");

  // a start clears the finished flag and the mirror position
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd == epg_pkg::CMD_START))
      |=> (!status.done && !status.pending))
    else $error("start request did not reset the walk state");

endmodule
`default_nettype wire

// ===== hdl/epg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epg_ctrl: request sequencer of the ellipse pixel generator
// Takes one request at a time, steps the datapath through setup multiplies,
// midpoint steps or mirror pops, and owns the result valid flag.
// ---------------------------------------------------------------------------
module epg_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              cmd,
  output logic             out_valid,
  input  wire              out_ready,
  input  epg_pkg::status_t status,
  output epg_pkg::op_t     op
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_RX   = 4'd1;
  localparam logic [3:0] S_MUL_RY   = 4'd2;
  localparam logic [3:0] S_MUL_CX   = 4'd3;
  localparam logic [3:0] S_MUL_SX   = 4'd4;
  localparam logic [3:0] S_INIT     = 4'd5;
  localparam logic [3:0] S_SW_CY    = 4'd6;
  localparam logic [3:0] S_SW_SY    = 4'd7;
  localparam logic [3:0] S_SW_INIT  = 4'd8;
  localparam logic [3:0] S_STEP_A   = 4'd9;
  localparam logic [3:0] S_STEP_B   = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;
  localparam logic [3:0] S_EMIT_INV = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;
  logic       out_load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (op == epg_pkg::OP_EMIT) || (op == epg_pkg::OP_EMIT_INV);

  always_comb begin
    state_next = state;
    op         = epg_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == epg_pkg::CMD_START) begin
            op         = epg_pkg::OP_LOAD;
            state_next = S_MUL_RX;
          end else if (status.done) begin
            state_next = S_EMIT_INV;
          end else if (status.pending) begin
            state_next = S_EMIT;
          end else if (status.advance) begin
            state_next = S_STEP_A;
          end else if (!status.region) begin
            state_next = S_SW_CY;
          end else begin
            // end of region two: mark finished and answer invalid
            op         = epg_pkg::OP_FINISH;
            state_next = S_EMIT_INV;
          end
        end
      end
      S_MUL_RX: begin
        op         = epg_pkg::OP_MUL_RX;
        state_next = S_MUL_RY;
      end
      S_MUL_RY: begin
        op         = epg_pkg::OP_MUL_RY;
        state_next = S_MUL_CX;
      end
      S_MUL_CX: begin
        op         = epg_pkg::OP_MUL_CX;
        state_next = S_MUL_SX;
      end
      S_MUL_SX: begin
        op         = epg_pkg::OP_MUL_SX;
        state_next = S_INIT;
      end
      S_INIT: begin
        op         = epg_pkg::OP_INIT;
        state_next = S_EMIT;
      end
      S_SW_CY: begin
        op         = epg_pkg::OP_SW_CY;
        state_next = S_SW_SY;
      end
      S_SW_SY: begin
        op         = epg_pkg::OP_SW_SY;
        state_next = S_SW_INIT;
      end
      S_SW_INIT: begin
        op         = epg_pkg::OP_SW_INIT;
        state_next = S_EMIT;
      end
      S_STEP_A: begin
        op         = epg_pkg::OP_STEP_A;
        state_next = S_STEP_B;
      end
      S_STEP_B: begin
        op         = epg_pkg::OP_STEP_B;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (slot_free) begin
          op         = epg_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_EMIT_INV: begin
        if (slot_free) begin
          op         = epg_pkg::OP_EMIT_INV;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/epg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epg_datapath: geometry registers, shared multiplier and midpoint terms
// Executes one operation per cycle as commanded, mirrors the current
// first-quadrant point around the centre and holds the result register.
// ---------------------------------------------------------------------------
module epg_datapath #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RADIUS = 4095
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  epg_pkg::op_t                          op,
  input  wire signed [epg_pkg::CENTER_W-1:0]    center_x,
  input  wire signed [epg_pkg::CENTER_W-1:0]    center_y,
  input  wire        [epg_pkg::RADIUS_W-1:0]    radius_x,
  input  wire        [epg_pkg::RADIUS_W-1:0]    radius_y,
  output epg_pkg::status_t                      status,
  output logic signed [COORD_BITS-1:0]          pixel_x,
  output logic signed [COORD_BITS-1:0]          pixel_y,
  output logic                                  pixel_valid
);

  localparam int TW   = epg_pkg::TERM_W;
  localparam int RW   = epg_pkg::RADIUS_W;
  localparam int SW   = epg_pkg::SQ_W;
  localparam int PW   = epg_pkg::PROD_W;
  localparam int AW   = epg_pkg::MUL_A_W;
  localparam int BW   = epg_pkg::MUL_B_W;
  localparam int UW   = epg_pkg::SUM_W;
  localparam int CW   = epg_pkg::CENTER_W;
  localparam int KEEP = (COORD_BITS < epg_pkg::OUT_W) ? COORD_BITS : epg_pkg::OUT_W;

  logic signed [CW-1:0] centre_x_reg;
  logic signed [CW-1:0] centre_y_reg;
  logic [RW-1:0]        radius_x_reg;
  logic [RW-1:0]        radius_y_reg;
  logic [SW-1:0]        two_a_squared;
  logic [SW-1:0]        two_b_squared;
  logic [RW-1:0]        quad_x;
  logic [RW-1:0]        quad_y;
  logic signed [TW-1:0] change_x;
  logic signed [TW-1:0] change_y;
  logic signed [TW-1:0] error_term;
  logic signed [TW-1:0] stop_x;
  logic signed [TW-1:0] stop_y;
  logic                 second_region;
  logic                 done_flag;
  logic [1:0]           mirror_head;
  logic signed [PW-1:0] prod;

  logic [RW-1:0]        rx_sat;
  logic [RW-1:0]        ry_sat;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_out;
  logic signed [BW-1:0] one_minus_2rx;
  logic signed [BW-1:0] one_minus_2ry;
  logic signed [TW-1:0] prod_term;
  logic signed [TW-1:0] two_a_term;
  logic signed [TW-1:0] two_b_term;
  logic signed [TW-1:0] test_sum;
  logic                 step_go;
  logic                 x_zero;
  logic                 y_zero;
  logic                 head_last;
  logic                 neg_x;
  logic                 neg_y;
  logic signed [UW-1:0] sum_x;
  logic signed [UW-1:0] sum_y;
  logic [COORD_BITS-1:0] pix_x_next;
  logic [COORD_BITS-1:0] pix_y_next;

  // clamp radii to the configured maximum
  assign rx_sat = (32'(radius_x) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_x;
  assign ry_sat = (32'(radius_y) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_y;

  assign one_minus_2rx = BW'(1) - signed'({1'b0, radius_x_reg, 1'b0});
  assign one_minus_2ry = BW'(1) - signed'({1'b0, radius_y_reg, 1'b0});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      epg_pkg::OP_MUL_RX: begin
        mul_a = signed'(AW'(radius_x_reg));
        mul_b = signed'(BW'(radius_x_reg));
      end
      epg_pkg::OP_MUL_RY: begin
        mul_a = signed'(AW'(radius_y_reg));
        mul_b = signed'(BW'(radius_y_reg));
      end
      epg_pkg::OP_MUL_CX: begin
        // prod holds ry*ry here
        mul_a = signed'(AW'(prod[SW-1:0]));
        mul_b = one_minus_2rx;
      end
      epg_pkg::OP_MUL_SX: begin
        mul_a = signed'(AW'(two_b_squared));
        mul_b = signed'(BW'(radius_x_reg));
      end
      epg_pkg::OP_SW_CY: begin
        mul_a = signed'(AW'(two_a_squared[SW-1:1]));
        mul_b = one_minus_2ry;
      end
      epg_pkg::OP_SW_SY: begin
        mul_a = signed'(AW'(two_a_squared));
        mul_b = signed'(BW'(radius_y_reg));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out    = mul_a * mul_b;
  assign prod_term  = TW'(prod);
  assign two_a_term = signed'(TW'(two_a_squared));
  assign two_b_term = signed'(TW'(two_b_squared));

  // second half of a midpoint step: decide the dependent axis move
  assign test_sum = (error_term <<< 1) + (second_region ? change_y : change_x);
  assign step_go  = !test_sum[TW-1] && (test_sum != '0);

  assign status.done    = done_flag;
  assign status.pending = (mirror_head != 2'd0);
  assign status.region  = second_region;
  assign status.advance = second_region ? (stop_x < stop_y) : (stop_x > stop_y);

  // mirror the current point: one, two or four pixels
  assign x_zero = (quad_x == '0);
  assign y_zero = (quad_y == '0);

  always_comb begin
    if (x_zero && y_zero) begin
      head_last = 1'b1;
      neg_x     = 1'b0;
      neg_y     = 1'b0;
    end else if (x_zero || y_zero) begin
      head_last = (mirror_head == 2'd1);
      neg_x     = (mirror_head == 2'd1);
      neg_y     = (mirror_head == 2'd1);
    end else begin
      head_last = (mirror_head == 2'd3);
      neg_x     = (mirror_head == 2'd1) || (mirror_head == 2'd2);
      neg_y     = mirror_head[1];
    end
  end

  assign sum_x = neg_x ? (UW'(centre_x_reg) - signed'(UW'(quad_x)))
                       : (UW'(centre_x_reg) + signed'(UW'(quad_x)));
  assign sum_y = neg_y ? (UW'(centre_y_reg) - signed'(UW'(quad_y)))
                       : (UW'(centre_y_reg) + signed'(UW'(quad_y)));

  always_comb begin
    pix_x_next           = '0;
    pix_y_next           = '0;
    pix_x_next[KEEP-1:0] = sum_x[KEEP-1:0];
    pix_y_next[KEEP-1:0] = sum_y[KEEP-1:0];
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      done_flag     <= 1'b1;
      second_region <= 1'b0;
      mirror_head   <= 2'd0;
      pixel_valid   <= 1'b0;
    end else begin
      case (op)
        epg_pkg::OP_LOAD: begin
          done_flag     <= 1'b0;
          second_region <= 1'b0;
          mirror_head   <= 2'd0;
        end
        epg_pkg::OP_SW_INIT: begin
          second_region <= 1'b1;
        end
        epg_pkg::OP_FINISH: begin
          done_flag <= 1'b1;
        end
        epg_pkg::OP_EMIT: begin
          pixel_valid <= 1'b1;
          mirror_head <= head_last ? 2'd0 : mirror_head + 2'd1;
        end
        epg_pkg::OP_EMIT_INV: begin
          pixel_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // geometry, midpoint terms and result payload
  always_ff @(posedge clk) begin
    case (op)
      epg_pkg::OP_LOAD: begin
        centre_x_reg <= center_x;
        centre_y_reg <= center_y;
        radius_x_reg <= rx_sat;
        radius_y_reg <= ry_sat;
      end
      epg_pkg::OP_MUL_RX: begin
        prod <= mul_out;
      end
      epg_pkg::OP_MUL_RY: begin
        two_a_squared <= {prod[SW-2:0], 1'b0};
        change_y      <= prod_term;
        prod          <= mul_out;
      end
      epg_pkg::OP_MUL_CX: begin
        two_b_squared <= {prod[SW-2:0], 1'b0};
        prod          <= mul_out;
      end
      epg_pkg::OP_MUL_SX: begin
        change_x <= prod_term;
        prod     <= mul_out;
      end
      epg_pkg::OP_INIT: begin
        stop_x     <= prod_term;
        stop_y     <= '0;
        quad_x     <= radius_x_reg;
        quad_y     <= '0;
        error_term <= '0;
      end
      epg_pkg::OP_SW_CY: begin
        prod <= mul_out;
      end
      epg_pkg::OP_SW_SY: begin
        change_y <= prod_term;
        prod     <= mul_out;
      end
      epg_pkg::OP_SW_INIT: begin
        stop_y     <= prod_term;
        stop_x     <= '0;
        quad_x     <= '0;
        quad_y     <= radius_y_reg;
        change_x   <= signed'(TW'(two_b_squared[SW-1:1]));
        error_term <= '0;
      end
      epg_pkg::OP_STEP_A: begin
        if (!second_region) begin
          quad_y     <= quad_y + RW'(1'b1);
          stop_y     <= stop_y + two_a_term;
          error_term <= error_term + change_y;
          change_y   <= change_y + two_a_term;
        end else begin
          quad_x     <= quad_x + RW'(1'b1);
          stop_x     <= stop_x + two_b_term;
          error_term <= error_term + change_x;
          change_x   <= change_x + two_b_term;
        end
      end
      epg_pkg::OP_STEP_B: begin
        if (step_go) begin
          if (!second_region) begin
            quad_x     <= quad_x - RW'(1'b1);
            stop_x     <= stop_x - two_b_term;
            error_term <= error_term + change_x;
            change_x   <= change_x + two_b_term;
          end else begin
            quad_y     <= quad_y - RW'(1'b1);
            stop_y     <= stop_y - two_a_term;
            error_term <= error_term + change_y;
            change_y   <= change_y + two_a_term;
          end
        end
      end
      epg_pkg::OP_EMIT: begin
        pixel_x <= signed'(pix_x_next);
        pixel_y <= signed'(pix_y_next);
      end
      epg_pkg::OP_EMIT_INV: begin
        pixel_x <= '0;
        pixel_y <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sim/tb_ellipse_pixel_generator_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ellipse_pixel_generator_unit: self-checking bench for the ellipse rasterizer
// Sends start and next requests with random gaps. A cycle-free midpoint
// tracker computes the pixel that each accepted request should return. Each
// returned pixel is checked in order against that prediction.
// ---------------------------------------------------------------------------
module tb_ellipse_pixel_generator_unit;

  localparam int CW = epg_pkg::CENTER_W;
  localparam int RW = epg_pkg::RADIUS_W;
  localparam int OW = epg_pkg::OUT_W;

  typedef struct {
    logic                 cmd;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [RW-1:0] rx;
    logic        [RW-1:0] ry;
    bit                   drain;
  } ellipse_req_t;

  typedef struct {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic                 vld;
  } pixel_t;

  localparam int N_RANDOM  = 1900;
  localparam int HOLD_AT   = 500;
  localparam int HOLD_LEN  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 cmd       = epg_pkg::CMD_NEXT;
  logic signed [CW-1:0] center_x  = '0;
  logic signed [CW-1:0] center_y  = '0;
  logic        [RW-1:0] radius_x  = '0;
  logic        [RW-1:0] radius_y  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] pixel_x;
  logic signed [OW-1:0] pixel_y;
  logic                 pixel_valid;

  ellipse_req_t req_q[$];
  ellipse_req_t cur_req;
  pixel_t       pixel_expect_q[$];

  int n_sent    = 0;
  int n_recv    = 0;
  int n_starts  = 0;
  int n_pixels  = 0;
  int n_invalid = 0;
  int n_errors  = 0;
  int send_gap  = 0;
  int rdy_gap   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Midpoint tracker state
  int     el_cx, el_cy, el_rx, el_ry;
  int     el_qx, el_qy;
  longint el_two_a2, el_two_b2;
  longint el_dx, el_dy, el_err, el_lim_x, el_lim_y;
  bit     el_region2 = 1'b0;
  bit     el_done    = 1'b1;
  pixel_t mirror_q[$];

  ellipse_pixel_generator_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic pixel_t make_pixel(int px, int py, logic vld);
    pixel_t p;
    p.x   = OW'(px);
    p.y   = OW'(py);
    p.vld = vld;
    return p;
  endfunction

  // Queue the mirrored pixels of a first-quadrant point
  function automatic void load_mirrors(int x, int y);
    mirror_q.delete();
    if (x == 0 && y == 0) begin
      mirror_q.push_back(make_pixel(el_cx, el_cy, 1'b1));
    end else if (x == 0) begin
      mirror_q.push_back(make_pixel(el_cx, el_cy + y, 1'b1));
      mirror_q.push_back(make_pixel(el_cx, el_cy - y, 1'b1));
    end else if (y == 0) begin
      mirror_q.push_back(make_pixel(el_cx + x, el_cy, 1'b1));
      mirror_q.push_back(make_pixel(el_cx - x, el_cy, 1'b1));
    end else begin
      mirror_q.push_back(make_pixel(el_cx + x, el_cy + y, 1'b1));
      mirror_q.push_back(make_pixel(el_cx - x, el_cy + y, 1'b1));
      mirror_q.push_back(make_pixel(el_cx - x, el_cy - y, 1'b1));
      mirror_q.push_back(make_pixel(el_cx + x, el_cy - y, 1'b1));
    end
  endfunction

  function automatic pixel_t next_pixel(ellipse_req_t r);
    longint rx;
    longint ry;
    if (r.cmd == epg_pkg::CMD_START) begin
      el_cx      = int'(r.cx);
      el_cy      = int'(r.cy);
      el_rx      = int'(r.rx);
      el_ry      = int'(r.ry);
      rx         = longint'(el_rx);
      ry         = longint'(el_ry);
      el_two_a2  = 2 * rx * rx;
      el_two_b2  = 2 * ry * ry;
      el_qx      = el_rx;
      el_qy      = 0;
      el_dx      = ry * ry * (1 - 2 * rx);
      el_dy      = rx * rx;
      el_err     = 0;
      el_lim_x   = el_two_b2 * rx;
      el_lim_y   = 0;
      el_region2 = 1'b0;
      el_done    = 1'b0;
      load_mirrors(el_qx, el_qy);
      return mirror_q.pop_front();
    end
    if (el_done) return make_pixel(0, 0, 1'b0);
    if (mirror_q.size() > 0) return mirror_q.pop_front();
    if (!el_region2) begin
      if (el_lim_x > el_lim_y) begin
        el_qy++;
        el_lim_y += el_two_a2;
        el_err   += el_dy;
        el_dy    += el_two_a2;
        if (2 * el_err + el_dx > 0) begin
          el_qx--;
          el_lim_x -= el_two_b2;
          el_err   += el_dx;
          el_dx    += el_two_b2;
        end
      end else begin
        // switch to region two, restarting at the top of the ellipse
        rx         = longint'(el_rx);
        ry         = longint'(el_ry);
        el_region2 = 1'b1;
        el_qx      = 0;
        el_qy      = el_ry;
        el_dx      = ry * ry;
        el_dy      = rx * rx * (1 - 2 * ry);
        el_err     = 0;
        el_lim_x   = 0;
        el_lim_y   = el_two_a2 * ry;
      end
    end else begin
      if (el_lim_x < el_lim_y) begin
        el_qx++;
        el_lim_x += el_two_b2;
        el_err   += el_dx;
        el_dx    += el_two_b2;
        if (2 * el_err + el_dy > 0) begin
          el_qy--;
          el_lim_y -= el_two_a2;
          el_err   += el_dy;
          el_dy    += el_two_a2;
        end
      end else begin
        el_done = 1'b1;
        return make_pixel(0, 0, 1'b0);
      end
    end
    load_mirrors(el_qx, el_qy);
    return mirror_q.pop_front();
  endfunction

  // Mostly short gaps, a few long ones; none at all in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 50);
  endfunction

  task automatic add_req(logic c, int cx, int cy, int rx, int ry, bit drain);
    ellipse_req_t r;
    r.cmd   = c;
    r.cx    = CW'(cx);
    r.cy    = CW'(cy);
    r.rx    = RW'(rx);
    r.ry    = RW'(ry);
    r.drain = drain;
    req_q.push_back(r);
  endtask

  // Request driver
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pixel_expect_q.push_back(next_pixel(cur_req));
        if (cur_req.cmd == epg_pkg::CMD_START) n_starts++;
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0 && !(req_q[0].drain && n_sent != n_recv)) begin
          cur_req  = req_q.pop_front();
          offer    = 1'b1;
          send_gap = pick_gap(((n_sent / 128) % 4) == 2);
        end
        in_valid <= offer;
        if (offer) begin
          cmd      <= cur_req.cmd;
          center_x <= cur_req.cx;
          center_y <= cur_req.cy;
          radius_x <= cur_req.rx;
          radius_y <= cur_req.ry;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d v=%0b",
                   $realtime, pixel_x, pixel_y, pixel_valid);
          n_errors++;
        end else begin
          want = pixel_expect_q.pop_front();
          if (pixel_x !== want.x || pixel_y !== want.y || pixel_valid !== want.vld) begin
            $display("%0t: result %0d mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
                     $realtime, n_recv, want.x, want.y, want.vld,
                     pixel_x, pixel_y, pixel_valid);
            n_errors++;
          end
          if (want.vld) n_pixels++;
          else n_invalid++;
        end
        n_recv++;
      end
      // hold off once for a long stretch so the block backs up
      if (!hold_done && n_recv >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rdy_gap = pick_gap(((n_recv / 150) % 4) == 1);
      end
    end
  end

  initial begin
    int total;
    int seq_no;
    int cls;
    int rx;
    int ry;
    int n_next;

    // Directed: next before any start, zero radii, extremes, degenerate lines
    add_req(epg_pkg::CMD_NEXT, 0, 0, 0, 0, 1'b0);
    add_req(epg_pkg::CMD_START, 0, 0, 0, 0, 1'b1);
    repeat (3) add_req(epg_pkg::CMD_NEXT, 0, 0, 0, 0, 1'b0);
    add_req(epg_pkg::CMD_START, -16384, 16383, 4095, 4095, 1'b1);
    repeat (5) add_req(epg_pkg::CMD_NEXT, 16383, -16384, 4095, 4095, 1'b0);
    add_req(epg_pkg::CMD_START, 16383, -16384, 4095, 0, 1'b0);
    repeat (3) add_req(epg_pkg::CMD_NEXT, -1, -1, 0, 4095, 1'b0);
    add_req(epg_pkg::CMD_START, 100, -50, 0, 3, 1'b0);
    repeat (3) add_req(epg_pkg::CMD_NEXT, 0, 0, 0, 0, 1'b0);
    add_req(epg_pkg::CMD_START, -7, 9, 1, 1, 1'b0);
    repeat (5) add_req(epg_pkg::CMD_NEXT, 0, 0, 0, 0, 1'b0);
    total = req_q.size();

    // Random: mostly whole small ellipses, some cut short, a few huge ones
    seq_no = 0;
    while (total < 25 + N_RANDOM) begin
      cls = $urandom_range(0, 99);
      if (cls < 80) begin
        rx     = $urandom_range(0, 12);
        ry     = $urandom_range(0, 12);
        n_next = ($urandom_range(0, 9) < 8) ? 4 * (rx + ry) + 8 + $urandom_range(0, 2)
                                             : $urandom_range(0, 4 * (rx + ry));
      end else if (cls < 92) begin
        rx     = $urandom_range(13, 60);
        ry     = $urandom_range(0, 60);
        n_next = $urandom_range(0, 1) ? 4 * (rx + ry) + 8 : $urandom_range(0, 60);
      end else begin
        rx     = $urandom_range(61, 4095);
        ry     = $urandom_range(0, 4095);
        n_next = $urandom_range(0, 40);
      end
      if ($urandom_range(0, 1)) begin
        cls = rx;
        rx  = ry;
        ry  = cls;
      end
      add_req(epg_pkg::CMD_START, $urandom_range(0, 32767) - 16384,
              $urandom_range(0, 32767) - 16384, rx, ry, (seq_no % 8) == 3);
      repeat (n_next) begin
        add_req(epg_pkg::CMD_NEXT, $urandom_range(0, 32767) - 16384,
                $urandom_range(0, 32767) - 16384,
                $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
      end
      total += 1 + n_next;
      seq_no++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (pixel_expect_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d requests in %0d ellipses; got %0d pixels and %0d finished results.",
             n_sent, n_starts, n_pixels, n_invalid);
    $display("Receiver held off for %0d cycles once; sender drained between sequences.",
             HOLD_LEN);
    if (n_errors == 0 && pixel_expect_q.size() == 0) begin
      $display("tb_ellipse_pixel_generator_unit OK");
    end else begin
      $display("tb_ellipse_pixel_generator_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_ellipse_pixel_generator_unit NOT OK");
    $finish;
  end

endmodule

// ===== ellipse_pixel_generator_unit.f =====
hdl/epg_pkg.sv
hdl/epg_ctrl.sv
hdl/epg_datapath.sv
hdl/ellipse_pixel_generator_unit.sv
sim/tb_ellipse_pixel_generator_unit.sv
